### rtl/mpsc_pkg.sv
// mpsc_pkg: shared widths, constants and small code functions for the map point
// short code encoder. No dependencies; compiled first.
`timescale 1ns / 1ps

package mpsc_pkg;

    localparam int MPSC_COORD_BITS      = 30;
    localparam int MPSC_MAX_POINT_CHARS = 10;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int ZOOM_W  = 13;
    localparam int CHAR_W  = 7;
    localparam int ZCODE_W = 6;
    localparam int CFG_W   = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic [0:0]       REG_POINT_LENGTH = 1'b0;
    localparam logic [CFG_W-1:0] PT_LEN_RESET     = 4'd9;

    // fixed-point spans in units of 1e-7 degree
    localparam logic [33:0] LAT_HALF = 34'd900000000;
    localparam logic [33:0] LAT_SPAN = 34'd1800000000;
    localparam logic [33:0] LON_HALF = 34'd1800000000;
    localparam logic [33:0] LON_SPAN = 34'd3600000000;

    localparam logic [ZOOM_W-1:0] ZOOM_LOW  = 13'd1024;
    localparam logic [ZOOM_W-1:0] ZOOM_HIGH = 13'd5056;

    // quarter-level zoom code above level 4, clamped to 63
    function automatic logic [ZCODE_W-1:0] zoom_code(input logic [ZOOM_W-1:0] z);
        logic [ZOOM_W-1:0] diff;
        diff = z - ZOOM_LOW;
        if (z <= ZOOM_LOW) begin
            zoom_code = '0;
        end else if (z >= ZOOM_HIGH) begin
            zoom_code = '1;
        end else begin
            zoom_code = diff[11:6];
        end
    endfunction

    // url-safe base64 alphabet
    function automatic logic [CHAR_W-1:0] b64_char(input logic [ZCODE_W-1:0] idx);
        logic [CHAR_W-1:0] x;
        x = {1'b0, idx};
        if (idx < 6'd26) begin
            b64_char = x + 7'd65;
        end else if (idx < 6'd52) begin
            b64_char = x + 7'd71;
        end else if (idx < 6'd62) begin
            b64_char = x - 7'd4;
        end else if (idx == 6'd62) begin
            b64_char = 7'd45;
        end else begin
            b64_char = 7'd95;
        end
    endfunction

endpackage

### rtl/mpsc_if.sv
// mpsc_if: valid/ready channel interfaces for map points and code characters.
// Depends on mpsc_pkg for the field widths.
`timescale 1ns / 1ps

interface mpsc_in_if import mpsc_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [LAT_W-1:0]  latitude;
    logic signed [LON_W-1:0]  longitude;
    logic        [ZOOM_W-1:0] zoom_level;

    modport source (output valid, output latitude, output longitude, output zoom_level,
                    input ready);
    modport sink   (input valid, input latitude, input longitude, input zoom_level,
                    output ready);
endinterface

interface mpsc_out_if import mpsc_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] code_char;
    logic              last;

    modport source (output valid, output code_char, output last, input ready);
    modport sink   (input valid, input code_char, input last, output ready);
endinterface

### rtl/map_point_short_code_encoder.sv
// Map point short code encoder: top level with register port, character
// serializer and output register. Depends on mpsc_pkg, mpsc_if and mpsc_scale.
`timescale 1ns / 1ps

// Each map point request on i_pt produces point_length+1 characters on o_code
// (point_length saturates at MAX_POINT_CHARS): first the zoom character, then
// the interleaved latitude/longitude characters, the last one flagged. The
// output port carries one character per cycle while o_code.ready is held high.
// Points enter a five-stage scaling pipeline (reciprocal multiply with remainder
// correction) ahead of the serializer, so a new point is taken while earlier ones
// are still being scaled or sent.
// point_length is register 0 at address 0 and should only be written while idle.
module map_point_short_code_encoder import mpsc_pkg::*; #(
    parameter int COORD_BITS      = MPSC_COORD_BITS,
    parameter int MAX_POINT_CHARS = MPSC_MAX_POINT_CHARS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mpsc_in_if.sink               i_pt,
    mpsc_out_if.source            o_code,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int K  = COORD_BITS;
    localparam int SW = 3 * MAX_POINT_CHARS;
    localparam int CW = $clog2(MAX_POINT_CHARS + 1);

    // register port
    logic [CFG_W-1:0] r_pt_len;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_POINT_LENGTH);
    assign prdata   = (paddr[2:2] == REG_POINT_LENGTH) ?
                      {{(APB_DATA_W-CFG_W){1'b0}}, r_pt_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_len <= PT_LEN_RESET;
        end else if (w_cfg_wr) begin
            r_pt_len <= pwdata[CFG_W-1:0];
        end
    end

    // scaling pipeline
    logic               w_sc_valid, w_sc_ready;
    logic [K-1:0]       w_lat, w_lon;
    logic [ZCODE_W-1:0] w_zc;

    mpsc_scale #(
        .COORD_BITS (COORD_BITS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_pt.valid),
        .o_ready      (i_pt.ready),
        .i_latitude   (i_pt.latitude),
        .i_longitude  (i_pt.longitude),
        .i_zoom_level (i_pt.zoom_level),
        .o_valid      (w_sc_valid),
        .i_ready      (w_sc_ready),
        .o_lat_code   (w_lat),
        .o_lon_code   (w_lon),
        .o_zoom_code  (w_zc)
    );

    // serializer
    logic               r_busy;
    logic [CW-1:0]      r_cnt, r_len;
    logic [SW-1:0]      r_sh_lat, r_sh_lon;
    logic [ZCODE_W-1:0] r_zc;
    logic               r_ov;
    logic [CHAR_W-1:0]  r_oc;
    logic               r_ol;

    logic               w_emit, w_fin, w_load;
    logic [CW-1:0]      w_len;
    logic [K+SW-1:0]    w_lat_ext, w_lon_ext;
    logic [ZCODE_W-1:0] w_idx;
    logic [CW-1:0]      n_cnt;

    assign w_emit = r_busy && (!r_ov || o_code.ready);
    assign w_fin  = w_emit && (r_cnt == r_len);
    assign w_sc_ready = !r_busy || w_fin;
    assign w_load = w_sc_valid && w_sc_ready;
    assign w_len  = (32'(r_pt_len) > MAX_POINT_CHARS) ? CW'(MAX_POINT_CHARS) : CW'(r_pt_len);
    // left-align codes; missing low bits read as zero
    assign w_lat_ext = {w_lat, SW'(0)};
    assign w_lon_ext = {w_lon, SW'(0)};
    assign w_idx  = {r_sh_lat[SW-1], r_sh_lon[SW-1], r_sh_lat[SW-2], r_sh_lon[SW-2],
                     r_sh_lat[SW-3], r_sh_lon[SW-3]};
    assign n_cnt  = r_cnt + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end else if (w_emit) begin
                r_cnt  <= n_cnt;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_code.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_len    <= w_len;
            r_zc     <= w_zc;
            r_sh_lat <= w_lat_ext[K+SW-1 -: SW];
            r_sh_lon <= w_lon_ext[K+SW-1 -: SW];
        end else if (w_emit && (r_cnt != '0)) begin
            r_sh_lat <= r_sh_lat << 3;
            r_sh_lon <= r_sh_lon << 3;
        end
        if (w_emit) begin
            r_oc <= (r_cnt == '0) ? b64_char(r_zc) : b64_char(w_idx);
            r_ol <= (r_cnt == r_len);
        end
    end

    assign o_code.valid     = r_ov;
    assign o_code.code_char = r_oc;
    assign o_code.last      = r_ol;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= r_len) && (32'(r_len) <= MAX_POINT_CHARS))
        else $error("character count past point length");

    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> !r_busy || (r_cnt == '0))
        else $error("serializer did not restart after final character");

    a_cfg_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cfg_wr |=> $stable(r_pt_len))
        else $error("point length changed without a write");

endmodule

### rtl/mpsc_scale.sv
// mpsc_scale: five-stage pipeline that turns latitude, longitude and zoom into
// coordinate codes and a zoom code. Depends on mpsc_pkg.
`timescale 1ns / 1ps

module mpsc_scale import mpsc_pkg::*; #(
    parameter int COORD_BITS = MPSC_COORD_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [LAT_W-1:0]  i_latitude,
    input  logic signed [LON_W-1:0]  i_longitude,
    input  logic        [ZOOM_W-1:0] i_zoom_level,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [COORD_BITS-1:0]    o_lat_code,
    output logic [COORD_BITS-1:0]    o_lon_code,
    output logic [ZCODE_W-1:0]       o_zoom_code
);

    localparam int K = COORD_BITS;
    localparam logic [63:0] M64     = (64'd1 << K) - 64'd1;
    // floor reciprocals, 32 fraction bits; the estimate is low by at most two
    localparam logic [63:0] C_LAT64 = (M64 << 32) / 64'd1800000000;
    localparam logic [63:0] C_LON64 = (64'd1 << (K + 32)) / 64'd3600000000;
    localparam logic [31:0] C_LAT   = C_LAT64[31:0];
    localparam logic [31:0] C_LON   = C_LON64[31:0];
    localparam logic [K-1:0] M_K    = M64[K-1:0];
    localparam logic [33:0] LAT_SPAN2 = LAT_SPAN << 1;
    localparam logic [33:0] LON_SPAN2 = LON_SPAN << 1;
    localparam logic [33:0] LAT_SPAN3 = LAT_SPAN2 + LAT_SPAN;
    localparam logic [33:0] LON_SPAN3 = LON_SPAN2 + LON_SPAN;

    logic r_va, r_vb, r_vc, r_vd, r_ve;
    logic w_adv_a, w_adv_b, w_adv_c, w_adv_d, w_adv_e;

    // stage a: input register
    logic signed [LAT_W-1:0]  r_a_lat;
    logic signed [LON_W-1:0]  r_a_lon;
    logic        [ZOOM_W-1:0] r_a_zoom;

    // stage b: offsets, fold, clamp flags
    logic [30:0]        r_b_n;
    logic               r_b_lo, r_b_hi;
    logic [31:0]        r_b_c;
    logic [ZCODE_W-1:0] r_b_zc;

    // stage c: products and quotient estimates
    logic [33:0]        r_c_nm;
    logic [K-1:0]       r_c_ql, r_c_qo;
    logic [31:0]        r_c_c;
    logic               r_c_lo, r_c_hi;
    logic [ZCODE_W-1:0] r_c_zc;

    // stage d: estimate times divisor
    logic [33:0]        r_d_nm, r_d_qdl, r_d_qdo;
    logic [K-1:0]       r_d_ql, r_d_qo;
    logic [31:0]        r_d_c;
    logic               r_d_lo, r_d_hi;
    logic [ZCODE_W-1:0] r_d_zc;

    // stage e: corrected codes
    logic [K-1:0]       r_e_lat, r_e_lon;
    logic [ZCODE_W-1:0] r_e_zc;

    assign w_adv_e = !r_ve || i_ready;
    assign w_adv_d = !r_vd || w_adv_e;
    assign w_adv_c = !r_vc || w_adv_d;
    assign w_adv_b = !r_vb || w_adv_c;
    assign w_adv_a = !r_va || w_adv_b;
    assign o_ready = w_adv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            if (w_adv_a) r_va <= i_valid;
            if (w_adv_b) r_vb <= r_va;
            if (w_adv_c) r_vc <= r_vb;
            if (w_adv_d) r_vd <= r_vc;
            if (w_adv_e) r_ve <= r_vd;
        end
    end

    // stage b logic
    logic signed [31:0] w_n;
    logic [33:0]        w_c, w_cf;
    logic               w_c_neg, w_c_big;

    assign w_n     = {r_a_lat[LAT_W-1], r_a_lat} + 32'sd900000000;
    assign w_c     = {{2{r_a_lon[LON_W-1]}}, r_a_lon} + LON_HALF;
    assign w_c_neg = w_c[33];
    assign w_c_big = !w_c[33] && (w_c >= LON_SPAN);
    assign w_cf    = w_c_neg ? (w_c + LON_SPAN) : (w_c_big ? (w_c - LON_SPAN) : w_c);

    // stage c logic
    logic [63:0] w_nm, w_pl, w_po;
    assign w_nm = {33'd0, r_b_n} * M64;
    assign w_pl = {33'd0, r_b_n} * {32'd0, C_LAT};
    assign w_po = {32'd0, r_b_c} * {32'd0, C_LON};

    // stage d logic, low 34 bits are enough since the remainder stays below 2^34
    logic [33:0] w_qdl, w_qdo;
    assign w_qdl = 34'(r_c_ql) * LAT_SPAN;
    assign w_qdo = 34'(r_c_qo) * LON_SPAN;

    // stage e logic
    logic [33:0] w_rem_lat, w_rem_lon;
    logic [K+1:0] w_ql;
    logic [K:0]   w_qo;
    assign w_rem_lat = r_d_nm + LAT_HALF - r_d_qdl;
    assign w_rem_lon = (34'(r_d_c) << K) + LON_HALF - r_d_qdo;
    assign w_ql = (K+2)'(r_d_ql) + (K+2)'(w_rem_lat >= LAT_SPAN)
                + (K+2)'(w_rem_lat >= LAT_SPAN2);
    assign w_qo = (K+1)'(r_d_qo) + (K+1)'(w_rem_lon >= LON_SPAN)
                + (K+1)'(w_rem_lon >= LON_SPAN2);

    always_ff @(posedge i_clk) begin
        if (w_adv_a) begin
            r_a_lat  <= i_latitude;
            r_a_lon  <= i_longitude;
            r_a_zoom <= i_zoom_level;
        end
        if (w_adv_b) begin
            r_b_n  <= w_n[30:0];
            r_b_lo <= w_n[31];
            r_b_hi <= !w_n[31] && (w_n[30:0] > 31'd1800000000);
            r_b_c  <= w_cf[31:0];
            r_b_zc <= zoom_code(r_a_zoom);
        end
        if (w_adv_c) begin
            r_c_nm <= w_nm[33:0];
            r_c_ql <= w_pl[32 +: K];
            r_c_qo <= w_po[32 +: K];
            r_c_c  <= r_b_c;
            r_c_lo <= r_b_lo;
            r_c_hi <= r_b_hi;
            r_c_zc <= r_b_zc;
        end
        if (w_adv_d) begin
            r_d_nm  <= r_c_nm;
            r_d_qdl <= w_qdl;
            r_d_qdo <= w_qdo;
            r_d_ql  <= r_c_ql;
            r_d_qo  <= r_c_qo;
            r_d_c   <= r_c_c;
            r_d_lo  <= r_c_lo;
            r_d_hi  <= r_c_hi;
            r_d_zc  <= r_c_zc;
        end
        if (w_adv_e) begin
            if (r_d_lo) begin
                r_e_lat <= '0;
            end else if (r_d_hi) begin
                r_e_lat <= M_K;
            end else begin
                r_e_lat <= w_ql[K-1:0];
            end
            // a full span wraps to the start
            r_e_lon <= w_qo[K] ? '0 : w_qo[K-1:0];
            r_e_zc  <= r_d_zc;
        end
    end

    assign o_valid     = r_ve;
    assign o_lat_code  = r_e_lat;
    assign o_lon_code  = r_e_lon;
    assign o_zoom_code = r_e_zc;

    a_lat_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vd && !r_d_lo && !r_d_hi |-> w_rem_lat < LAT_SPAN3)
        else $error("latitude remainder out of correction range");

    a_lon_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vd |-> w_rem_lon < LON_SPAN3)
        else $error("longitude remainder out of correction range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ve && !i_ready |=> r_ve && $stable(r_e_lat) && $stable(r_e_lon))
        else $error("stalled code changed");

endmodule
